// ===== hw/rtl/ptt_pkg.sv =====
// ----------------------------------------------------------------------------
// ptt_pkg: shared types and constants of the periodic callback timer table
// Holds the table size, the field widths, the command codes and the token
// that walks down the row of slot cells.
// ----------------------------------------------------------------------------
package ptt_pkg;

    // table size and derived index width
    localparam int SLOT_COUNT = 4;
    localparam int SLOT_IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    // field widths of the items
    localparam int MODE_W   = 2;
    localparam int ID_W     = 16;
    localparam int PERIOD_W = 16;
    localparam int SLOT_W   = 2;
    localparam int MASK_W   = 4;

    // command codes carried in the input tuser
    typedef enum logic [MODE_W-1:0] {
        MODE_TICK     = 2'd0,
        MODE_REGISTER = 2'd1,
        MODE_CLEAR    = 2'd2
    } t_mode;

    // command and partial answer handed from cell to cell
    typedef struct packed {
        logic                valid;
        logic [MODE_W-1:0]   mode;
        logic [ID_W-1:0]     client_id;
        logic [PERIOD_W-1:0] period;
        logic                done;
        logic                ok;
        logic [SLOT_W-1:0]   slot;
        logic [MASK_W-1:0]   fired_mask;
    } t_token;

endpackage

// ===== hw/rtl/periodic_callback_timer_table.sv =====
// ----------------------------------------------------------------------------
// periodic_callback_timer_table: table of periodic software timer slots
// Row of slot cells; each command walks the row one cell per cycle.
// ----------------------------------------------------------------------------
// Usage:
//   Input items arrive on s_axis: tuser carries the mode (tick, register,
//   clear), tdata carries client_id and period. Each item gives exactly one
//   result on m_axis with ok, slot and fired_mask in tdata.
//   A register item claims the first free slot unless an earlier slot already
//   holds the id; a clear item frees the slot holding the id; a tick item
//   counts down every occupied slot and reports the slots that fire.
//   The command enters a head register and then passes the slot cells in
//   order, one cell per cycle, before its result is registered in the
//   output register. The table handles one item at a time: s_axis_tready
//   returns high in the cycle after the result is taken, so no new item is
//   accepted while one is in the row or waits in the output register.
//   While the receiver holds m_axis_tready low the result stays in the
//   output register and no new item is accepted.
//   Reset frees all slots and clears periods and countdowns.
// ----------------------------------------------------------------------------
module periodic_callback_timer_table (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // client_id [15:0], period [31:16]
    input  logic [1:0]  s_axis_tuser,   // mode [1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata    // ok [0], slot [2:1], fired_mask [6:3], zero [7]
);

    ptt_pkg::t_token r_head;
    ptt_pkg::t_token w_tok [ptt_pkg::SLOT_COUNT+1];
    logic            r_busy;
    logic            r_out_valid;
    logic            r_out_ok;
    logic [ptt_pkg::SLOT_W-1:0] r_out_slot;
    logic [ptt_pkg::MASK_W-1:0] r_out_mask;
    logic            w_in_accept;
    logic            w_out_accept;

    assign w_in_accept  = s_axis_tvalid && s_axis_tready;
    assign w_out_accept = r_out_valid && m_axis_tready;

    // head register: item enters the row
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head.valid <= 1'b0;
        end else begin
            r_head.valid <= w_in_accept;
        end
        if (w_in_accept) begin
            r_head.mode       <= s_axis_tuser;
            r_head.client_id  <= s_axis_tdata[15:0];
            r_head.period     <= s_axis_tdata[31:16];
            r_head.done       <= 1'b0;
            r_head.ok         <= (s_axis_tuser == ptt_pkg::MODE_TICK);
            r_head.slot       <= '0;
            r_head.fired_mask <= '0;
        end
    end

    assign w_tok[0] = r_head;

    // row of slot cells
    for (genvar k = 0; k < ptt_pkg::SLOT_COUNT; k++) begin : g_cell
        ptt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_index (ptt_pkg::SLOT_IDX_W'(k)),
            .i_tok   (w_tok[k]),
            .o_tok   (w_tok[k+1])
        );
    end

    // busy from accept until the result is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (w_in_accept) begin
            r_busy <= 1'b1;
        end else if (w_out_accept) begin
            r_busy <= 1'b0;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_tok[ptt_pkg::SLOT_COUNT].valid) begin
            r_out_valid <= 1'b1;
        end else if (w_out_accept) begin
            r_out_valid <= 1'b0;
        end
        if (w_tok[ptt_pkg::SLOT_COUNT].valid) begin
            r_out_ok   <= w_tok[ptt_pkg::SLOT_COUNT].ok;
            r_out_slot <= w_tok[ptt_pkg::SLOT_COUNT].slot;
            r_out_mask <= w_tok[ptt_pkg::SLOT_COUNT].fired_mask;
        end
    end

    assign s_axis_tready = !r_busy;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out_mask, r_out_slot, r_out_ok};

    // at most one item in flight anywhere in the row
    logic [ptt_pkg::SLOT_COUNT+1:0] w_live;
    always_comb begin
        for (int k = 0; k <= ptt_pkg::SLOT_COUNT; k++) begin
            w_live[k] = w_tok[k].valid;
        end
        w_live[ptt_pkg::SLOT_COUNT+1] = r_out_valid;
    end

    a_single_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_live))
        else $error("more than one item in the slot row");

    a_live_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_live != '0) |-> r_busy)
        else $error("item in the row while the table is not busy");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_accept |=> r_head.valid && !r_out_valid)
        else $error("accepted item did not enter the head register");

    a_mask_tick_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out_mask != '0) |-> r_out_ok && (r_out_slot == '0))
        else $error("fired mask on a result that is not a tick");

endmodule

// ===== hw/rtl/ptt_cell.sv =====
// ----------------------------------------------------------------------------
// ptt_cell: one timer slot of the table
// Holds client id, period and countdown of one slot, applies the token that
// arrives from the previous cell and hands the updated token to the next.
// ----------------------------------------------------------------------------
module ptt_cell (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [ptt_pkg::SLOT_IDX_W-1:0] i_index,
    input  ptt_pkg::t_token                i_tok,
    output ptt_pkg::t_token                o_tok
);

    logic [ptt_pkg::ID_W-1:0]     r_client, n_client;
    logic [ptt_pkg::PERIOD_W-1:0] r_period, n_period;
    logic [ptt_pkg::PERIOD_W-1:0] r_count,  n_count;
    ptt_pkg::t_token              r_tok,    n_tok;

    // slot update and token rewrite
    always_comb begin
        logic occupied;
        logic hit;
        logic fire;
        occupied = (r_client != '0);
        hit      = (r_client == i_tok.client_id);
        fire     = 1'b0;
        n_client = r_client;
        n_period = r_period;
        n_count  = r_count;
        n_tok    = i_tok;
        if (i_tok.valid && !i_tok.done) begin
            case (i_tok.mode)
                ptt_pkg::MODE_TICK: begin
                    if (occupied) begin
                        if (r_count == '0) begin
                            fire    = 1'b1;
                            n_count = r_period;
                        end else begin
                            n_count = r_count - 1'b1;
                        end
                    end
                end
                ptt_pkg::MODE_REGISTER: begin
                    if (hit) begin
                        n_tok.done = 1'b1;
                        n_tok.ok   = 1'b1;
                        n_tok.slot = ptt_pkg::SLOT_W'(i_index);
                    end else if (!occupied) begin
                        n_client   = i_tok.client_id;
                        n_period   = i_tok.period;
                        n_tok.done = 1'b1;
                        n_tok.ok   = 1'b1;
                        n_tok.slot = ptt_pkg::SLOT_W'(i_index);
                    end
                end
                ptt_pkg::MODE_CLEAR: begin
                    if (hit) begin
                        n_client   = '0;
                        n_tok.done = 1'b1;
                        n_tok.ok   = 1'b1;
                        n_tok.slot = ptt_pkg::SLOT_W'(i_index);
                    end
                end
                default: begin
                end
            endcase
        end
        // only slots with an index below MASK_W show in the mask (all four here)
        for (int b = 0; b < ptt_pkg::MASK_W; b++) begin
            n_tok.fired_mask[b] = i_tok.fired_mask[b] | (fire && (int'(i_index) == b));
        end
    end

    // slot state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_client <= '0;
            r_period <= '0;
            r_count  <= '0;
        end else begin
            r_client <= n_client;
            r_period <= n_period;
            r_count  <= n_count;
        end
    end

    // token register toward the next cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.valid <= 1'b0;
        end else begin
            r_tok.valid <= n_tok.valid;
        end
        r_tok.mode       <= n_tok.mode;
        r_tok.client_id  <= n_tok.client_id;
        r_tok.period     <= n_tok.period;
        r_tok.done       <= n_tok.done;
        r_tok.ok         <= n_tok.ok;
        r_tok.slot       <= n_tok.slot;
        r_tok.fired_mask <= n_tok.fired_mask;
    end

    assign o_tok = r_tok;

endmodule
